[src/tdpm_pkg.sv]
// ----------------------------------------------------------------------------
// tdpm_pkg
// Shared widths, action codes and payload types for the table DFA matcher.
// ----------------------------------------------------------------------------
package tdpm_pkg;

   localparam int STATE_W         = 8;
   localparam int BYTE_W          = 8;
   localparam int POS_W           = 31;
   localparam int ACTION_W        = 2;
   localparam int ALPHABET_SIZE   = 256;
   localparam int STATE_LIMIT     = 256;
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_PTR_W       = 2;
   localparam int RSP_CNT_W       = 3;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MARK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SCAN  = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [STATE_W-1:0]  state_index;
      logic [BYTE_W-1:0]   byte_value;
      logic [STATE_W-1:0]  target_state;
      logic                last_byte;
   } req_payload_type;

   typedef struct packed {
      logic               matched;
      logic [STATE_W-1:0] match_state;
      logic [POS_W-1:0]   position;
      logic               any_match;
      logic               end_of_buffer;
   } rsp_payload_type;

   typedef struct packed {
      logic clearing;
      logic s1_valid;
      logic s2_valid;
   } core_stat_type;

endpackage

[src/tdpm_req_if.sv]
// ----------------------------------------------------------------------------
// tdpm_req_if
// Request channel: load and scan beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdpm_req_if import tdpm_pkg::*;;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [STATE_W-1:0]  state_index;
   logic [BYTE_W-1:0]   byte_value;
   logic [STATE_W-1:0]  target_state;
   logic                last_byte;

   modport source (
      output valid, action, state_index, byte_value, target_state, last_byte,
      input  ready
   );

   modport sink (
      input  valid, action, state_index, byte_value, target_state, last_byte,
      output ready
   );

endinterface

[src/tdpm_rsp_if.sv]
// ----------------------------------------------------------------------------
// tdpm_rsp_if
// Response channel: match and end-of-buffer beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdpm_rsp_if import tdpm_pkg::*;;

   logic               valid;
   logic               ready;
   logic               matched;
   logic [STATE_W-1:0] match_state;
   logic [POS_W-1:0]   position;
   logic               any_match;
   logic               end_of_buffer;

   modport source (
      output valid, matched, match_state, position, any_match, end_of_buffer,
      input  ready
   );

   modport sink (
      input  valid, matched, match_state, position, any_match, end_of_buffer,
      output ready
   );

endinterface

[src/tdpm_scan_core.sv]
// ----------------------------------------------------------------------------
// tdpm_scan_core
// Transition and accepting-mark memories with a three-stage scan pipeline.
// Stage 0 reads the transition memory, stage 1 reads the mark memory at the
// reached state, stage 2 updates position and match history and emits beats.
// ----------------------------------------------------------------------------
module tdpm_scan_core import tdpm_pkg::*; #(
   parameter int NUM_STATES = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_accept,
   input  req_payload_type req_data,
   output logic            rsp_push,
   output rsp_payload_type rsp_data,
   output core_stat_type   stat
);

   localparam int STATES_USED = (NUM_STATES < STATE_LIMIT) ? NUM_STATES : STATE_LIMIT;
   localparam int SW          = $clog2(STATES_USED);
   localparam int MARK_DEPTH  = 1 << SW;
   localparam int AW          = SW + BYTE_W;
   localparam int TRANS_DEPTH = MARK_DEPTH * ALPHABET_SIZE;
   localparam logic [AW-1:0] CLR_LAST = AW'(TRANS_DEPTH - 1);

   logic [STATE_W-1:0] trans_mem [TRANS_DEPTH];
   logic               mark_mem  [MARK_DEPTH];

   logic               clearing_ff, clearing_in;
   logic [AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [STATE_W-1:0] cur_ff, cur_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               seen_ff, seen_in;

   logic               s1_valid_ff, s1_last_ff;
   logic               s2_valid_ff, s2_last_ff;
   logic [STATE_W-1:0] s2_state_ff;
   logic [STATE_W-1:0] trans_rd_ff;
   logic               mark_rd_ff;

   logic               st_ok, tgt_ok;
   logic               do_write, do_mark, do_scan;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               seen_now;

   // Decode the accepted beat; drop loads that name states out of range
   assign st_ok    = 32'(req_data.state_index) < 32'(NUM_STATES);
   assign tgt_ok   = 32'(req_data.target_state) < 32'(NUM_STATES);
   assign do_write = req_accept && (req_data.action == ACT_WRITE) && st_ok && tgt_ok;
   assign do_mark  = req_accept && (req_data.action == ACT_MARK) && st_ok;
   assign do_scan  = req_accept && (req_data.action == ACT_SCAN);

   // Forward the state reached by the scan in stage 1 into the next read address
   always_comb begin
      if (s1_valid_ff) begin
         cur_in = s1_last_ff ? '0 : trans_rd_ff;
      end else begin
         cur_in = cur_ff;
      end
   end

   assign rd_addr = {cur_in[SW-1:0], req_data.byte_value};
   assign wr_addr = {req_data.state_index[SW-1:0], req_data.byte_value};

   // Transition memory: clear sweep or load write, scan read
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         trans_mem[clr_cnt_ff] <= '0;
      end else if (do_write) begin
         trans_mem[wr_addr] <= req_data.target_state;
      end
      if (do_scan) begin
         trans_rd_ff <= trans_mem[rd_addr];
      end
   end

   // Mark memory: read returns the value before a same-cycle write
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mark_mem[clr_cnt_ff[SW-1:0]] <= 1'b0;
      end else if (do_mark) begin
         mark_mem[req_data.state_index[SW-1:0]] <= 1'b1;
      end
      if (s1_valid_ff) begin
         mark_rd_ff <= mark_mem[trans_rd_ff[SW-1:0]];
      end
   end

   // Sweep both memories once after reset
   always_comb begin
      clr_cnt_in  = clearing_ff ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      clearing_in = clearing_ff && (clr_cnt_ff != CLR_LAST);
   end

   // Stage 2: match history and saturating byte position
   assign seen_now = seen_ff | mark_rd_ff;

   always_comb begin
      pos_in  = pos_ff;
      seen_in = seen_ff;
      if (s2_valid_ff) begin
         if (s2_last_ff) begin
            pos_in  = '0;
            seen_in = 1'b0;
         end else begin
            pos_in  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
            seen_in = seen_now;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         cur_ff      <= '0;
         pos_ff      <= '0;
         seen_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
         cur_ff      <= cur_in;
         pos_ff      <= pos_in;
         seen_ff     <= seen_in;
         s1_valid_ff <= do_scan;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Advance the scan payload down the pipe
   always_ff @(posedge clock) begin
      s1_last_ff  <= req_data.last_byte;
      s2_last_ff  <= s1_last_ff;
      s2_state_ff <= trans_rd_ff;
   end

   // Emit a beat on a match or on the buffer's last byte
   assign rsp_push               = s2_valid_ff && (mark_rd_ff || s2_last_ff);
   assign rsp_data.matched       = mark_rd_ff;
   assign rsp_data.match_state   = s2_state_ff;
   assign rsp_data.position      = pos_ff;
   assign rsp_data.any_match     = seen_now;
   assign rsp_data.end_of_buffer = s2_last_ff;

   assign stat.clearing = clearing_ff;
   assign stat.s1_valid = s1_valid_ff;
   assign stat.s2_valid = s2_valid_ff;

endmodule

[src/tdpm_rsp_queue.sv]
// ----------------------------------------------------------------------------
// tdpm_rsp_queue
// Small response queue that decouples the scan pipe from the sink.
// ----------------------------------------------------------------------------
module tdpm_rsp_queue import tdpm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_payload_type      push_data,
   input  logic                 pop,
   output logic                 head_valid,
   output rsp_payload_type      head_data,
   output logic [RSP_CNT_W-1:0] count
);

   rsp_payload_type      slot_ff [RSP_QUEUE_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

[src/table_dfa_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// table_dfa_pattern_matcher
// Full-table DFA string matcher with load and scan beats on one channel.
// ----------------------------------------------------------------------------
// The block takes one request beat per cycle while ready is high, loads and
// scans alike. Each scan byte reads the transition memory at {current state,
// byte}; that memory's registered output is the next state and feeds the
// following read address directly, so consecutive bytes of a buffer stream
// at one per cycle. The reached state then reads the accepting-mark memory,
// and the final stage pushes a response into the four-entry output queue. Only
// matching bytes and the byte flagged last produce a response. Outside the
// clear sweep, request ready drops only while the output queue together with
// the beats in flight could fill it. After reset both memories are cleared
// by a sweep over 256 * 2**ceil(log2(min(NUM_STATES, 256))) transition
// entries (65536 at the default), during which request ready stays low.
// ----------------------------------------------------------------------------
module table_dfa_pattern_matcher import tdpm_pkg::*; #(
   parameter int NUM_STATES = 256
) (
   input logic        clock,
   input logic        reset,
   tdpm_req_if.sink   req_bus,
   tdpm_rsp_if.source rsp_bus
);

   req_payload_type      req_data;
   rsp_payload_type      core_rsp;
   rsp_payload_type      head_data;
   core_stat_type        stat;
   logic                 req_accept;
   logic                 core_push;
   logic                 q_pop;
   logic                 q_valid;
   logic [RSP_CNT_W-1:0] q_count;
   logic [RSP_CNT_W-1:0] q_committed;

   // Pack the request beat
   assign req_data.action       = req_bus.action;
   assign req_data.state_index  = req_bus.state_index;
   assign req_data.byte_value   = req_bus.byte_value;
   assign req_data.target_state = req_bus.target_state;
   assign req_data.last_byte    = req_bus.last_byte;

   // Hold ready low when the queue could overflow or during the clear sweep
   assign q_committed   = q_count + RSP_CNT_W'(stat.s1_valid) + RSP_CNT_W'(stat.s2_valid);
   assign req_bus.ready = !stat.clearing && (q_committed < RSP_CNT_W'(RSP_QUEUE_DEPTH));
   assign req_accept    = req_bus.valid && req_bus.ready;

   tdpm_scan_core #(
      .NUM_STATES (NUM_STATES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .rsp_push   (core_push),
      .rsp_data   (core_rsp),
      .stat       (stat)
   );

   tdpm_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (core_push),
      .push_data  (core_rsp),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (head_data),
      .count      (q_count)
   );

   // Drive the response beat from the queue head
   assign q_pop                 = q_valid && rsp_bus.ready;
   assign rsp_bus.valid         = q_valid;
   assign rsp_bus.matched       = head_data.matched;
   assign rsp_bus.match_state   = head_data.match_state;
   assign rsp_bus.position      = head_data.position;
   assign rsp_bus.any_match     = head_data.any_match;
   assign rsp_bus.end_of_buffer = head_data.end_of_buffer;

   // A push into a full queue must coincide with a pop
   a_queue_no_overflow : assert property (@(posedge clock) disable iff (reset)
      (core_push && (q_count == RSP_CNT_W'(RSP_QUEUE_DEPTH))) |-> q_pop)
      else $error("response queue overflow");

   // No request is taken while the memories are being cleared
   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !req_bus.ready)
      else $error("request accepted during clear sweep");

   // A matching beat always reports a match seen in its buffer
   a_match_sets_history : assert property (@(posedge clock) disable iff (reset)
      (core_push && core_rsp.matched) |-> core_rsp.any_match)
      else $error("match without match history");

endmodule
